@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FRFR_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frfr: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FRFR_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frfr: next-cycle check failed");

`endif

@@ design/frfr_pkg.sv @@
`timescale 1ns / 1ps

package frfr_pkg;

	// field widths
	localparam int ADDR_W  = 24;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 6;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HANZI_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ASCII_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND = 2'd2;

	localparam logic [BYTE_W-1:0] READ_COMMAND_RST = 8'h03;

	// glyph lengths in bytes
	localparam logic [LEN_W-1:0] LEN_HANZI = 6'd32;
	localparam logic [LEN_W-1:0] LEN_ASCII = 6'd16;
	localparam logic [LEN_W-1:0] LEN_NONE  = 6'd0;

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// one classified code, as handed from front to back
	typedef struct packed {
		logic              err;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
	} req_t;

endpackage

@@ design/frfr_code_if.sv @@
`timescale 1ns / 1ps

interface frfr_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_first;
	logic [7:0] code_second;

	modport source(output valid, code_first, code_second, input ready);
	modport sink(input valid, code_first, code_second, output ready);
endinterface

@@ design/frfr_result_if.sv @@
`timescale 1ns / 1ps

interface frfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       byte_kind;
	logic [5:0] glyph_length;
	logic       code_error;
	logic       last;

	modport source(output valid, bus_byte, byte_kind, glyph_length, code_error, last,
		input ready);
	modport sink(input valid, bus_byte, byte_kind, glyph_length, code_error, last,
		output ready);
endinterface

@@ design/font_rom_fetch_request_top.sv @@
`timescale 1ns / 1ps

// Font ROM fetch request generator. Each accepted item is a one- or two-byte
// character code; a GB2312 pair (symbol rows A1..A9, hanzi rows B0..F7) gives
// a 32-byte glyph address from hanzi_base, printable ASCII gives a 16-byte
// glyph address from ascii_base. A mapped code yields four results (read
// command, then address high, middle, low); an unmapped code yields a single
// result with code_error set. Results leave one per cycle from one output
// register while the output is not stalled; an accepted code passes the front
// register, the request queue and the output register in that order. A
// front register stage and a two-entry queue let codes be taken while the
// output side is busy or stalled. Registers are written through cfg_we,
// cfg_index and cfg_data and should only change while no code is in flight.
module font_rom_fetch_request_top import frfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	frfr_code_if.sink            code,
	frfr_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [ADDR_W-1:0] hanzi_base_q;
	logic [ADDR_W-1:0] ascii_base_q;
	logic [BYTE_W-1:0] read_command_q;
	req_t              front_req;
	logic              front_valid;
	logic              front_ready;
	req_t              head;
	logic              head_valid;
	logic              head_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hanzi_base_q   <= '0;
			ascii_base_q   <= '0;
			read_command_q <= READ_COMMAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HANZI_BASE:   hanzi_base_q   <= cfg_data[ADDR_W-1:0];
				CFG_ASCII_BASE:   ascii_base_q   <= cfg_data[ADDR_W-1:0];
				CFG_READ_COMMAND: read_command_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	frfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code       (code),
		.hanzi_base (hanzi_base_q),
		.ascii_base (ascii_base_q),
		.req        (front_req),
		.req_valid  (front_valid),
		.req_ready  (front_ready)
	);

	frfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (front_req),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_data  (head),
		.out_valid (head_valid),
		.out_ready (head_pop)
	);

	frfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.head_pop     (head_pop),
		.read_command (read_command_q),
		.result       (result)
	);

endmodule

@@ design/frfr_front.sv @@
`timescale 1ns / 1ps

module frfr_front import frfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	frfr_code_if.sink         code,
	input  logic [ADDR_W-1:0] hanzi_base,
	input  logic [ADDR_W-1:0] ascii_base,
	output req_t              req,
	output logic              req_valid,
	input  logic              req_ready
);

	localparam int ENTRY_W = 14;
	localparam logic [7:0] ROW_SYM_FIRST = 8'hA1;
	localparam logic [7:0] ROW_SYM_LAST  = 8'hA9;
	localparam logic [7:0] ROW_HZ_FIRST  = 8'hB0;
	localparam logic [7:0] ROW_HZ_LAST   = 8'hF7;
	localparam logic [7:0] COL_FIRST     = 8'hA1;
	localparam logic [7:0] COL_LAST      = 8'hFE;
	localparam logic [7:0] ASCII_FIRST   = 8'h20;
	localparam logic [7:0] ASCII_LAST    = 8'h7E;
	localparam logic [ENTRY_W-1:0] ROW_LEN        = 14'd94;
	localparam logic [ENTRY_W-1:0] HZ_ENTRY_OFFSET = 14'd846;

	logic [7:0]         hi;
	logic [7:0]         lo;
	logic               col_ok;
	logic               is_sym;
	logic               is_hz;
	logic               is_ascii;
	logic [7:0]         row_b;
	logic [7:0]         col_b;
	logic [7:0]         asc_b;
	logic [ENTRY_W-1:0] entry;
	logic [ADDR_W-1:0]  hz_addr;
	logic [ADDR_W-1:0]  asc_addr;
	req_t               req_d;
	logic               v_s1;
	req_t               req_s1;
	logic               accept;

	assign hi = code.code_first;
	assign lo = code.code_second;

	// region decode
	assign col_ok   = (lo >= COL_FIRST) && (lo <= COL_LAST);
	assign is_sym   = hi[7] && col_ok && (hi >= ROW_SYM_FIRST) && (hi <= ROW_SYM_LAST);
	assign is_hz    = hi[7] && col_ok && (hi >= ROW_HZ_FIRST) && (hi <= ROW_HZ_LAST);
	assign is_ascii = !hi[7] && (hi >= ASCII_FIRST) && (hi <= ASCII_LAST);

	// glyph index and byte address
	assign row_b = is_hz ? (hi - ROW_HZ_FIRST) : (hi - ROW_SYM_FIRST);
	assign col_b = lo - COL_FIRST;
	assign asc_b = hi - ASCII_FIRST;
	assign entry = ENTRY_W'(row_b[6:0]) * ROW_LEN + ENTRY_W'(col_b[6:0])
		+ (is_hz ? HZ_ENTRY_OFFSET : '0);
	assign hz_addr  = hanzi_base + ADDR_W'({entry, 5'b0});
	assign asc_addr = ascii_base + ADDR_W'({asc_b[6:0], 4'b0});

	always_comb begin
		req_d.err  = 1'b0;
		req_d.len  = LEN_HANZI;
		req_d.addr = hz_addr;
		if (is_ascii) begin
			req_d.len  = LEN_ASCII;
			req_d.addr = asc_addr;
		end else if (!(is_sym || is_hz)) begin
			req_d.err  = 1'b1;
			req_d.len  = LEN_NONE;
			req_d.addr = '0;
		end
	end

	// one register stage; takes a new item whenever it is empty or its content moves on
	assign code.ready = !v_s1 || req_ready;
	assign accept     = code.valid && code.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (code.ready) begin
			v_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_d;
		end
	end

	assign req       = req_s1;
	assign req_valid = v_s1;

endmodule

@@ design/frfr_queue.sv @@
`timescale 1ns / 1ps

module frfr_queue import frfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t in_data,
	input  logic in_valid,
	output logic in_ready,
	output req_t out_data,
	output logic out_valid,
	input  logic out_ready
);

	req_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ design/frfr_back.sv @@
`timescale 1ns / 1ps

module frfr_back import frfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              head,
	input  logic              head_valid,
	output logic              head_pop,
	input  logic [BYTE_W-1:0] read_command,
	frfr_result_if.source     result
);

	typedef enum logic [1:0] {
		BEAT_CMD,
		BEAT_HI,
		BEAT_MID,
		BEAT_LO
	} beat_t;

	beat_t             beat_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] bus_byte_q;
	logic              byte_kind_q;
	logic [LEN_W-1:0]  glyph_length_q;
	logic              code_error_q;
	logic              last_q;
	logic              load;
	logic              last_beat;
	logic [BYTE_W-1:0] beat_byte;

	// output register refills when empty or being taken
	assign load      = !out_valid_q || result.ready;
	assign last_beat = head.err || (beat_q == BEAT_LO);
	assign head_pop  = load && head_valid && last_beat;

	always_comb begin
		case (beat_q)
			BEAT_CMD: beat_byte = read_command;
			BEAT_HI:  beat_byte = head.addr[23:16];
			BEAT_MID: beat_byte = head.addr[15:8];
			BEAT_LO:  beat_byte = head.addr[7:0];
			default:  beat_byte = read_command;
		endcase
	end

	// beat sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= BEAT_CMD;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				beat_q <= last_beat ? BEAT_CMD : beat_t'(beat_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			bus_byte_q     <= head.err ? '0 : beat_byte;
			byte_kind_q    <= !head.err && (beat_q != BEAT_CMD);
			glyph_length_q <= head.len;
			code_error_q   <= head.err;
			last_q         <= last_beat;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.bus_byte     = bus_byte_q;
	assign result.byte_kind    = byte_kind_q;
	assign result.glyph_length = glyph_length_q;
	assign result.code_error   = code_error_q;
	assign result.last         = last_q;

endmodule

@@ design/frfr_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_kind,
	input logic [5:0] glyph_length,
	input logic       code_error,
	input logic       last
);

	// a stalled result holds
	`FRFR_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(glyph_length) && $stable(last))

	// an error is a lone, empty result
	`FRFR_ASSERT_IMP(a_err_shape, clk, arst_n, out_valid && code_error, last && glyph_length == 6'd0 && byte_kind == 1'b0)

	// the beats of one code follow without a gap
	`FRFR_ASSERT_NXT(a_no_gap, clk, arst_n, out_valid && out_ready && !last, out_valid && !code_error)

	// glyph length is constant within one code
	`FRFR_ASSERT_NXT(a_len_same, clk, arst_n, out_valid && out_ready && !last, $stable(glyph_length))

	// the command byte is followed by an address byte
	`FRFR_ASSERT_NXT(a_cmd_then_addr, clk, arst_n, out_valid && out_ready && !last && !byte_kind, byte_kind)

endmodule

bind font_rom_fetch_request_top frfr_checker u_frfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.byte_kind    (result.byte_kind),
	.glyph_length (result.glyph_length),
	.code_error   (result.code_error),
	.last         (result.last)
);
